@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is active
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked on the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vrdq_pkg.sv @@
// ----------------------------------------------------------------------------
// vrdq_pkg
// Shared types and constants of the record deque pool.
// ----------------------------------------------------------------------------
package vrdq_pkg;

    localparam int DEF_POOL_BYTES   = 4096;
    localparam int DEF_MAX_RECORD   = 64;
    localparam int DEF_HEADER_BYTES = 2;

    typedef enum logic [1:0] {
        REQ_PUSH       = 2'd0,
        REQ_POP_OLDEST = 2'd1,
        REQ_POP_NEWEST = 2'd2,
        REQ_CLEAR      = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [6:0] record_length;
        logic       last_byte;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [6:0] out_length;
        logic [1:0] status;
        logic       is_empty;
    } rsp_beat_t;

endpackage

@@ rtl/vrdq_stream_if.sv @@
// ----------------------------------------------------------------------------
// vrdq_stream_if
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface vrdq_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/variable_record_deque_pool.sv @@
// Sequencing: clear, rejected push and pop on an empty pool go straight to their result;
//   the first byte of a record writes the length and distance header bytes before its data,
//   a last byte zero-fills the missing bytes; a pop reads length and distance, then streams
//   one byte per cycle while rsp is ready. One request at a time; compaction moves the
//   live region byte by byte through the pool memory, a read and then a write per byte.
// Reset: rst_n clears offsets, count and push state at once; pool contents stay undefined.
// ----------------------------------------------------------------------------
// variable_record_deque_pool
// Byte pool of variable-length records, popped from either end.
// ----------------------------------------------------------------------------
module variable_record_deque_pool
    import vrdq_pkg::*;
#(
    parameter int POOL_BYTES   = DEF_POOL_BYTES,
    parameter int MAX_RECORD   = DEF_MAX_RECORD,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic clk,
    input  logic rst_n,
    vrdq_stream_if.sink   req,
    vrdq_stream_if.source rsp
);
`include "assert_macros.svh"

    localparam int AW = $clog2(POOL_BYTES);
    localparam int OW = AW + 1;   // offsets may equal the pool size
    localparam logic [OW:0]  POOL_X = (OW+1)'(POOL_BYTES);
    localparam logic [OW-1:0] HDR_O = OW'(HEADER_BYTES);
    localparam logic [6:0]   MAX_L  = 7'(MAX_RECORD);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CMP_RD   = 13'b0000000000010,
        S_CMP_WR   = 13'b0000000000100,
        S_HDR_LEN  = 13'b0000000001000,
        S_HDR_DIST = 13'b0000000010000,
        S_PDATA    = 13'b0000000100000,
        S_ZFILL    = 13'b0000001000000,
        S_POP_LEN  = 13'b0000010000000,
        S_POP_DIST = 13'b0000100000000,
        S_PAY      = 13'b0001000000000,
        S_EMIT     = 13'b0010000000000,
        S_SPARE0   = 13'b0100000000000,
        S_SPARE1   = 13'b1000000000000
    } state_t;

    // control state
    state_t      state_reg, state_next;
    logic [OW-1:0] oldest_reg, oldest_next;
    logic [OW-1:0] newest_reg, newest_next;
    logic [OW-1:0] used_reg, used_next;
    logic [11:0] count_reg, count_next;
    logic [6:0]  prog_reg, prog_next;
    logic        rej_reg, rej_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // working registers of the current request
    logic [OW-1:0] base_reg, base_next;     // record start of a pop
    logic [OW-1:0] cmp_reg, cmp_next;       // compaction byte index
    logic [6:0]  idx_reg, idx_next;         // payload byte index
    logic [6:0]  len_reg, len_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        newest_pop_reg, newest_pop_next;
    rsp_beat_t   res_reg, res_next;         // pending single result
    rsp_beat_t   rsp_reg, rsp_next;

    // pool port
    logic          we, re;
    logic [OW-1:0] waddr_o, raddr_o;
    logic [7:0]    wdata, rdata;

    vrdq_ram #(.DEPTH(POOL_BYTES), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_o[AW-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_o[AW-1:0]),
        .rdata (rdata)
    );

    logic slot_free;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // helpers
    logic [OW:0]   fit_sum;
    logic [OW-1:0] size_o;
    logic [6:0]    rd_len;
    logic [OW-1:0] dist_o;
    logic [11:0]   count_dec, count_inc;

    assign size_o    = HDR_O + OW'(req.data.record_length);
    assign fit_sum   = {1'b0, used_reg} + {1'b0, size_o};
    assign rd_len    = (rdata > {1'b0, MAX_L}) ? MAX_L : rdata[6:0];
    assign dist_o    = OW'(rdata);
    assign count_dec = count_reg - 12'd1;
    assign count_inc = count_reg + 12'd1;

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        prog_next       = prog_reg;
        rej_next        = rej_reg;
        base_next       = base_reg;
        cmp_next        = cmp_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        newest_pop_next = newest_pop_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        we      = 1'b0;
        re      = 1'b0;
        waddr_o = used_reg;
        raddr_o = base_reg;
        wdata   = 8'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    data_next = req.data.data_byte;
                    last_next = req.data.last_byte;
                    res_next  = '0;
                    res_next.is_empty = (count_reg == 12'd0);
                    unique case (req.data.req_type)
                        REQ_CLEAR:
                        begin
                            oldest_next = '0;
                            newest_next = '0;
                            used_next   = '0;
                            count_next  = '0;
                            prog_next   = '0;
                            rej_next    = 1'b0;
                            res_next.is_empty = 1'b1;
                            state_next  = S_EMIT;
                        end
                        REQ_POP_OLDEST, REQ_POP_NEWEST:
                        begin
                            prog_next = '0;
                            rej_next  = 1'b0;
                            newest_pop_next = (req.data.req_type == REQ_POP_NEWEST);
                            if (count_reg == 12'd0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                base_next  = (req.data.req_type == REQ_POP_NEWEST) ?
                                             newest_reg : oldest_reg;
                                raddr_o    = base_next;
                                re         = 1'b1;
                                state_next = S_POP_LEN;
                            end
                        end
                        default:
                        begin
                            if (rej_reg)
                            begin
                                if (req.data.last_byte)
                                begin
                                    rej_next = 1'b0;
                                end
                                res_next.status = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (prog_reg == 7'd0)
                            begin
                                len_next = req.data.record_length;
                                if (req.data.record_length > MAX_L)
                                begin
                                    rej_next        = !req.data.last_byte;
                                    res_next.status = ST_FULL;
                                    state_next      = S_EMIT;
                                end
                                else if (fit_sum > POOL_X)
                                begin
                                    if (size_o <= oldest_reg)
                                    begin
                                        cmp_next   = '0;
                                        state_next = S_CMP_RD;
                                    end
                                    else
                                    begin
                                        rej_next        = !req.data.last_byte;
                                        res_next.status = ST_FULL;
                                        state_next      = S_EMIT;
                                    end
                                end
                                else
                                begin
                                    state_next = S_HDR_LEN;
                                end
                            end
                            else
                            begin
                                state_next = S_PDATA;
                            end
                        end
                    endcase
                end
            end

            // move the live region down to offset zero, byte by byte
            S_CMP_RD:
            begin
                if (cmp_reg == used_reg - oldest_reg)
                begin
                    newest_next = newest_reg - oldest_reg;
                    used_next   = used_reg - oldest_reg;
                    oldest_next = '0;
                    state_next  = S_HDR_LEN;
                end
                else
                begin
                    raddr_o    = oldest_reg + cmp_reg;
                    re         = 1'b1;
                    state_next = S_CMP_WR;
                end
            end
            S_CMP_WR:
            begin
                we         = 1'b1;
                waddr_o    = cmp_reg;
                wdata      = rdata;
                cmp_next   = cmp_reg + OW'(1);
                state_next = S_CMP_RD;
            end

            S_HDR_LEN:
            begin
                we         = 1'b1;
                waddr_o    = used_reg;
                wdata      = {1'b0, len_reg};
                state_next = S_HDR_DIST;
            end
            S_HDR_DIST:
            begin
                logic [OW-1:0] back;
                back       = used_reg - newest_reg;
                we         = 1'b1;
                waddr_o    = used_reg + OW'(1);
                wdata      = (count_reg != 12'd0) ? back[7:0] : 8'd0;
                prog_next  = 7'd1;
                state_next = S_PDATA;
            end

            S_PDATA:
            begin
                logic [6:0] pos;
                pos      = prog_reg - 7'd1;
                we       = (pos < len_reg);
                waddr_o  = used_reg + HDR_O + OW'(pos);
                wdata    = data_reg;
                res_next.out_length = len_reg;
                res_next.status     = ST_OK;
                if (last_reg)
                begin
                    idx_next   = prog_reg;
                    state_next = S_ZFILL;
                end
                else
                begin
                    if (prog_reg != 7'd127)
                    begin
                        prog_next = prog_reg + 7'd1;
                    end
                    state_next = S_EMIT;
                end
            end

            // a short record gets zeros for its missing bytes, then commits
            S_ZFILL:
            begin
                if (idx_reg < len_reg)
                begin
                    we       = 1'b1;
                    waddr_o  = used_reg + HDR_O + OW'(idx_reg);
                    wdata    = 8'd0;
                    idx_next = idx_reg + 7'd1;
                end
                else
                begin
                    newest_next = used_reg;
                    used_next   = used_reg + HDR_O + OW'(len_reg);
                    count_next  = count_inc;
                    prog_next   = '0;
                    res_next.is_empty = (count_inc == 12'd0);
                    state_next  = S_EMIT;
                end
            end

            S_POP_LEN:
            begin
                len_next   = rd_len;
                raddr_o    = base_reg + OW'(1);
                re         = 1'b1;
                state_next = S_POP_DIST;
            end
            S_POP_DIST:
            begin
                if (newest_pop_reg)
                begin
                    used_next = newest_reg;
                    if (dist_o <= newest_reg && newest_reg - dist_o >= oldest_reg)
                    begin
                        newest_next = newest_reg - dist_o;
                    end
                    else
                    begin
                        newest_next = oldest_reg;
                    end
                end
                else
                begin
                    oldest_next = oldest_reg + HDR_O + OW'(len_reg);
                end
                count_next = count_dec;
                if (count_dec == 12'd0)
                begin
                    oldest_next = '0;
                    newest_next = '0;
                    used_next   = '0;
                end
                res_next          = '0;
                res_next.is_empty = (count_dec == 12'd0);
                idx_next          = '0;
                if (len_reg == 7'd0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    raddr_o    = base_reg + HDR_O;
                    re         = 1'b1;
                    state_next = S_PAY;
                end
            end

            // stream payload; next read goes out with each beat
            S_PAY:
            begin
                if (slot_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next            = res_reg;
                    rsp_next.out_byte   = rdata;
                    rsp_next.out_length = len_reg;
                    rsp_next.status     = ST_OK;
                    rsp_next.out_last   = (idx_reg == len_reg - 7'd1);
                    if (idx_reg == len_reg - 7'd1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                        raddr_o  = base_reg + HDR_O + OW'(idx_reg) + OW'(1);
                        re       = 1'b1;
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next          = res_reg;
                    rsp_next.out_last = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            prog_reg      <= '0;
            rej_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            prog_reg      <= prog_next;
            rej_reg       <= rej_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        cmp_reg        <= cmp_next;
        idx_reg        <= idx_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        last_reg       <= last_next;
        newest_pop_reg <= newest_pop_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    // live region stays inside the pool and ordered
    `ASSERT_CLK(a_used_in_pool, {1'b0, used_reg} <= POOL_X, "used end beyond pool")
    `ASSERT_CLK(a_oldest_le_used, oldest_reg <= used_reg, "oldest offset past used end")
    `ASSERT_CLK(a_empty_offsets, (count_reg != 12'd0) || (used_reg == '0),
                "empty pool with nonzero used end")
endmodule

@@ rtl/vrdq_ram.sv @@
// ----------------------------------------------------------------------------
// vrdq_ram
// Byte-wide simple dual-port pool memory, registered read.
// ----------------------------------------------------------------------------
module vrdq_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ dv/tb_variable_record_deque_pool.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_record_deque_pool
// Self-checking bench for the record deque pool: request beats are predicted
// against a behavioural copy of the pool, response beats checked in order.
// ----------------------------------------------------------------------------
module tb_variable_record_deque_pool;
    import vrdq_pkg::*;

    // Small pool so that full-pool rejects and compaction are hit often
    localparam int POOL     = 256;
    localparam int MAXREC   = DEF_MAX_RECORD;
    localparam int HDR      = DEF_HEADER_BYTES;
    localparam int TIMEOUT  = 400000;
    localparam int DRAIN    = 200;
    localparam int N_RANDOM = 350;

    logic clk;
    logic rst_n;

    vrdq_stream_if #(.T(req_beat_t)) req_ch ();
    vrdq_stream_if #(.T(rsp_beat_t)) rsp_ch ();

    variable_record_deque_pool #(
        .POOL_BYTES   (POOL),
        .MAX_RECORD   (MAXREC),
        .HEADER_BYTES (HDR)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Request beats waiting to be driven, response beats still owed by the pool
    req_beat_t   pending_beats[$];
    rsp_beat_t   owed_rsp[$];
    int          beats_total;
    int          beats_taken;
    int          mismatches;
    int          cycle_count;

    // Shadow of the pool
    logic [7:0]  pool_mem [POOL];
    int unsigned oldest_off;
    int unsigned newest_off;
    int unsigned used_end;
    int unsigned rec_count;
    int unsigned push_prog;
    bit          push_rej;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idling phase follows the share of beats accepted so far:
    // receiver gappy first, then sender gappy, then flat out.
    function automatic int idle_phase();
        if (beats_taken < beats_total / 3)
            return 0;
        else if (beats_taken < (2 * beats_total) / 3)
            return 1;
        return 2;
    endfunction

    task automatic pool_wr(input int unsigned addr, input logic [7:0] val);
        if (addr < POOL)
            pool_mem[addr] = val;
    endtask

    function automatic rsp_beat_t mk_rsp(input logic [7:0] b, input int unsigned len,
                                         input status_t st);
        rsp_beat_t r;
        r.out_byte   = b;
        r.out_last   = 1'b0;
        r.out_length = len[6:0];
        r.status     = st;
        r.is_empty   = 1'b0;
        return r;
    endfunction

    // Work out the response beats caused by one request and queue them
    task automatic predict_pool(input req_beat_t rq);
        rsp_beat_t   beats[$];
        int unsigned len;
        int unsigned size;
        int unsigned addr;
        int unsigned back_dist;
        int unsigned idx;
        bit          ok;
        bit          from_new;
        if (rq.req_type == REQ_PUSH)
        begin
            ok = 1'b1;
            if (push_rej)
            begin
                // rest of a rejected record: swallowed until its last beat
                if (rq.last_byte)
                    push_rej = 1'b0;
                beats.push_back(mk_rsp(8'd0, 0, ST_FULL));
                ok = 1'b0;
            end
            else if (push_prog == 0)
            begin
                len  = rq.record_length;
                size = HDR + len;
                ok   = (len <= MAXREC);
                if (ok && used_end + size > POOL)
                begin
                    // compact down to offset zero when the freed front is enough
                    if (size <= oldest_off && oldest_off <= used_end)
                    begin
                        for (int i = 0; i < int'(used_end - oldest_off); i++)
                            pool_mem[i] = pool_mem[oldest_off + i];
                        newest_off -= oldest_off;
                        used_end   -= oldest_off;
                        oldest_off  = 0;
                    end
                    else
                        ok = 1'b0;
                end
                if (!ok)
                begin
                    push_rej = !rq.last_byte;
                    beats.push_back(mk_rsp(8'd0, 0, ST_FULL));
                end
                else
                begin
                    pool_wr(used_end, len[7:0]);
                    back_dist = (rec_count != 0) ? used_end - newest_off : 0;
                    pool_wr(used_end + 1, back_dist[7:0]);
                    for (int i = 2; i < HDR; i++)
                        pool_wr(used_end + i, 8'd0);
                    push_prog = 1;
                end
            end
            if (ok)
            begin
                len = pool_mem[used_end];
                if (len > MAXREC)
                    len = MAXREC;
                idx = push_prog - 1;
                // bytes past the declared length are dropped
                if (idx < len)
                    pool_wr(used_end + HDR + idx, rq.data_byte);
                beats.push_back(mk_rsp(8'd0, len, ST_OK));
                if (rq.last_byte)
                begin
                    // short record: zero-fill the remainder
                    for (int unsigned i = push_prog; i < len; i++)
                        pool_wr(used_end + HDR + i, 8'd0);
                    newest_off = used_end;
                    used_end  += HDR + len;
                    rec_count  = (rec_count + 1) & 12'hFFF;
                    push_prog  = 0;
                end
                else if (push_prog < 127)
                    push_prog++;
            end
        end
        else
        begin
            // any non-push abandons an unfinished record
            push_prog = 0;
            push_rej  = 1'b0;
            if (rq.req_type == REQ_CLEAR)
            begin
                oldest_off = 0;
                newest_off = 0;
                used_end   = 0;
                rec_count  = 0;
                beats.push_back(mk_rsp(8'd0, 0, ST_OK));
            end
            else if (rec_count == 0)
                beats.push_back(mk_rsp(8'd0, 0, ST_EMPTY));
            else
            begin
                from_new = (rq.req_type == REQ_POP_NEWEST);
                addr = from_new ? newest_off : oldest_off;
                len  = pool_mem[addr];
                if (len > MAXREC)
                    len = MAXREC;
                back_dist = pool_mem[addr + 1];
                for (int unsigned i = 0; i < len; i++)
                    beats.push_back(mk_rsp(pool_mem[addr + HDR + i], len, ST_OK));
                if (len == 0)
                    beats.push_back(mk_rsp(8'd0, 0, ST_OK));
                if (from_new)
                begin
                    used_end = newest_off;
                    if (back_dist <= newest_off && newest_off - back_dist >= oldest_off)
                        newest_off -= back_dist;
                    else
                        newest_off = oldest_off;
                end
                else
                    oldest_off += HDR + len;
                rec_count--;
                if (rec_count == 0)
                begin
                    oldest_off = 0;
                    newest_off = 0;
                    used_end   = 0;
                end
            end
        end
        foreach (beats[i])
            beats[i].is_empty = (rec_count == 0);
        beats[beats.size() - 1].out_last = 1'b1;
        foreach (beats[i])
            owed_rsp.push_back(beats[i]);
    endtask

    task automatic add_beat(input req_type_t t, input logic [7:0] d,
                            input logic [6:0] len, input logic last);
        req_beat_t b;
        b.req_type      = t;
        b.data_byte     = d;
        b.record_length = len;
        b.last_byte     = last;
        pending_beats.push_back(b);
    endtask

    // Record of nbytes push beats with random payload, closed on its last beat if close is set; len on every beat
    task automatic add_record(input int len, input int nbytes, input bit close);
        for (int i = 0; i < nbytes; i++)
            add_beat(REQ_PUSH, 8'($urandom), 7'(len), close && (i == nbytes - 1));
    endtask

    // Driver: a beat leaves on acceptance and the next is offered at once unless the idling phase holds it back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_pool(req_ch.data);
                beats_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_beats.size() > 0 &&
                    !(idle_phase() == 0 && $urandom_range(99) < 18) &&
                    !(idle_phase() == 1 && $urandom_range(99) < 78))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_beats.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison of every field
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (idle_phase() == 0)
                rsp_ch.ready <= ($urandom_range(99) >= 78);
            else if (idle_phase() == 1)
                rsp_ch.ready <= ($urandom_range(99) >= 18);
            else
                rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response beat %h", $realtime,
                                 rsp_ch.data);
                end
                else if (rsp_ch.data !== owed_rsp[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: exp %h/%b/%0d/%0d/%b got %h/%b/%0d/%0d/%b",
                                 $realtime, owed_rsp[0].out_byte, owed_rsp[0].out_last,
                                 owed_rsp[0].out_length, owed_rsp[0].status,
                                 owed_rsp[0].is_empty, rsp_ch.data.out_byte,
                                 rsp_ch.data.out_last, rsp_ch.data.out_length,
                                 rsp_ch.data.status, rsp_ch.data.is_empty);
                    void'(owed_rsp.pop_front());
                end
                else
                    void'(owed_rsp.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int r;
        int len;
        int nb;
        rst_n       = 1'b0;
        beats_taken = 0;
        beats_total = 1;
        mismatches  = 0;
        cycle_count = 0;
        oldest_off  = 0;
        newest_off  = 0;
        used_end    = 0;
        rec_count   = 0;
        push_prog   = 0;
        push_rej    = 1'b0;

        // Directed part
        add_beat(REQ_POP_OLDEST, 8'h00, 7'd0, 1'b0);   // pop on empty pool
        add_beat(REQ_POP_NEWEST, 8'h00, 7'd0, 1'b0);
        add_beat(REQ_PUSH, 8'hFF, 7'd0, 1'b1);         // zero-length record
        add_beat(REQ_PUSH, 8'h00, 7'd3, 1'b0);         // short record, zero-filled
        add_beat(REQ_PUSH, 8'hFF, 7'd3, 1'b1);
        add_beat(REQ_PUSH, 8'hA5, 7'd2, 1'b0);         // long record, extra dropped
        add_beat(REQ_PUSH, 8'h5A, 7'd2, 1'b0);
        add_beat(REQ_PUSH, 8'hFF, 7'd2, 1'b0);
        add_beat(REQ_PUSH, 8'h00, 7'd2, 1'b1);
        add_beat(REQ_PUSH, 8'h11, 7'd127, 1'b0);       // oversized: rejected to the end
        add_beat(REQ_PUSH, 8'h22, 7'd127, 1'b1);
        add_beat(REQ_PUSH, 8'h33, 7'd65, 1'b1);
        add_beat(REQ_POP_NEWEST, 8'h00, 7'd0, 1'b0);
        add_beat(REQ_POP_OLDEST, 8'h00, 7'd0, 1'b0);
        add_beat(REQ_PUSH, 8'h44, 7'd5, 1'b0);         // pop mid-push abandons it
        add_beat(REQ_POP_OLDEST, 8'h00, 7'd0, 1'b0);
        add_beat(REQ_PUSH, 8'h55, 7'd4, 1'b0);         // clear mid-push
        add_beat(REQ_CLEAR, 8'h00, 7'd0, 1'b0);
        add_record(64, 64, 1'b1);                      // largest record
        add_beat(REQ_POP_NEWEST, 8'h00, 7'd0, 1'b0);

        // Random part: mostly well-formed records, some broken or stray beats
        while (pending_beats.size() < N_RANDOM)
        begin
            r = $urandom_range(99);
            if (r < 62)
            begin
                nb = $urandom_range(99);
                if (nb < 85)
                    len = $urandom_range(12);
                else if (nb < 95)
                    len = $urandom_range(64, 13);
                else
                    len = $urandom_range(127, 65);
                nb = (len == 0) ? 1 : len;
                if (len > 64)
                    nb = $urandom_range(3, 1);
                else if ($urandom_range(9) == 0)
                    nb = $urandom_range(nb, 1);
                else if ($urandom_range(9) == 0)
                    nb = nb + $urandom_range(3, 1);
                add_record(len, nb, $urandom_range(19) != 0);
            end
            else if (r < 77)
                add_beat(REQ_POP_OLDEST, 8'($urandom), 7'($urandom), 1'($urandom));
            else if (r < 90)
                add_beat(REQ_POP_NEWEST, 8'($urandom), 7'($urandom), 1'($urandom));
            else if (r < 93)
                add_beat(REQ_CLEAR, 8'($urandom), 7'($urandom), 1'($urandom));
            else
                add_beat(REQ_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        beats_total = pending_beats.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (owed_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && owed_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
